// ----- rtl/fpst_pkg.sv -----
// Shared constants and codes for the frame pacing slot tracker.
`default_nettype none
package fpst_pkg;

    // slot table geometry
    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);

    // field widths
    localparam int TIME_W = 64;
    localparam int ID_W   = 32;
    localparam int ACT_W  = 3;
    localparam int ST_W   = 2;
    localparam int OFF_W  = 63;
    localparam int PH_W   = 2;

    // bit-serial divider
    localparam int DIV_W     = 64;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // guard band subtracted from the display time to get the due time
    localparam logic [TIME_W-1:0] HALF_MS_NS = TIME_W'(500000);

    // actions
    localparam logic [ACT_W-1:0] ACT_SAMPLE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PREDICT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WAIT    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BEGIN   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DISCARD = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DELIVER = 3'd5;

    // result status
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BUSY     = 2'd1;
    localparam logic [ST_W-1:0] ST_MISMATCH = 2'd2;
    localparam logic [ST_W-1:0] ST_WRONG    = 2'd3;

    // slot phases
    localparam logic [PH_W-1:0] PH_READY  = 2'd0;
    localparam logic [PH_W-1:0] PH_PRED   = 2'd1;
    localparam logic [PH_W-1:0] PH_WAITED = 2'd2;
    localparam logic [PH_W-1:0] PH_BEGUN  = 2'd3;

    typedef logic [TIME_W-1:0] time_ns_t;

endpackage
`default_nettype wire

// ----- rtl/fpst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fpst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/fpst_div.sv -----
// Bit-serial restoring divider that returns the 64-bit remainder.
`default_nettype none
module fpst_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [fpst_pkg::DIV_W-1:0] dividend,
    input  wire logic [fpst_pkg::DIV_W-1:0] divisor,
    output logic                        done,
    output logic [fpst_pkg::DIV_W-1:0]  remainder
);
    import fpst_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dq_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    // shift one dividend bit into the partial remainder and try the subtract
    assign trial = {rem_reg, dq_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    // sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
            dq_reg  <= {dq_reg[DIV_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ----- rtl/frame_pacing_slot_tracker_core.sv -----
// Frame pacing slot tracker: top level with sequencer, slot table and result register.
//
// Every item runs to completion before the next one is taken. A sample item,
// or an item with an unused action, goes from acceptance straight to the
// result state. A predict item runs the grid alignment through the bit-serial
// divider when the display period is known and the last display lies at or
// before the time floor; otherwise it skips the divider, and a busy slot ends
// it with a busy status. Wait, begin, discard and deliver items take the slot
// number from the low bits of the frame id, followed by one read of the slot
// RAM and the check. An accepted deliver then forms the offset in S_DLV. A
// result that is still waiting in the output register holds back the next
// result until it is taken. The output register lets a new item be taken
// while an earlier result waits. The slot phases live in flops cleared by
// reset, so the block is ready right after reset.
`default_nettype none
module frame_pacing_slot_tracker_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [fpst_pkg::ACT_W-1:0]     action,
    input  wire logic [fpst_pkg::TIME_W-1:0]    now_ns,
    input  wire logic [fpst_pkg::ID_W-1:0]      mark_id,
    input  wire logic [fpst_pkg::TIME_W-1:0]    sample_display_ns,
    input  wire logic [fpst_pkg::TIME_W-1:0]    sample_period_ns,
    input  wire logic [fpst_pkg::TIME_W-1:0]    sample_extra_ns,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [fpst_pkg::ST_W-1:0]           status,
    output logic [fpst_pkg::ID_W-1:0]           new_frame_id,
    output logic [fpst_pkg::TIME_W-1:0]         display_ns,
    output logic [fpst_pkg::TIME_W-1:0]         wake_ns,
    output logic [fpst_pkg::TIME_W-1:0]         period_ns,
    output logic                                late,
    output logic [fpst_pkg::OFF_W-1:0]          offset_ns
);
    import fpst_pkg::*;

    localparam int RAM_W = ID_W + TIME_W;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_PRED = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_ADD  = 4'd4;
    localparam logic [3:0] S_FIN1 = 4'd5;
    localparam logic [3:0] S_FIN2 = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_CHK  = 4'd8;
    localparam logic [3:0] S_DLV  = 4'd9;
    localparam logic [3:0] S_RESP = 4'd10;

    logic [3:0]        state_reg;
    logic              out_valid_reg;

    // latched item
    logic [ACT_W-1:0]  act_reg;
    time_ns_t          now_reg;
    logic [ID_W-1:0]   fid_reg;

    // tracker state
    logic [ID_W-1:0]   id_cnt_reg;
    logic [SLOT_W-1:0] nslot_reg;
    time_ns_t          last_ret_reg;
    time_ns_t          last_disp_reg;
    time_ns_t          period_reg;
    time_ns_t          extra_reg;
    logic [PH_W-1:0]   phase_reg [SLOTS];

    // working registers
    time_ns_t          floor_reg;
    time_ns_t          disp_reg;
    time_ns_t          wake_reg;
    time_ns_t          due_reg;
    time_ns_t          diff_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [ST_W-1:0]   st_reg;
    logic              late_reg;
    logic [OFF_W-1:0]  off_reg;

    // divider hookup
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_rem;

    // slot RAM hookup
    logic              ram_we;
    logic [RAM_W-1:0]  ram_wdata;
    logic [RAM_W-1:0]  ram_rdata;

    logic [ID_W-1:0]   nid;
    logic [PH_W-1:0]   pred_phase;
    logic [PH_W-1:0]   mark_phase;
    logic [ID_W-1:0]   slot_owner;
    time_ns_t          slot_due;
    logic              phase_ok;
    logic [PH_W-1:0]   phase_after;
    logic [TIME_W:0]   grid_sum;
    time_ns_t          neg_diff;
    logic              load_out;
    logic              pred_ok;
    logic              dlv_ok;

    assign nid        = id_cnt_reg + 1'b1;
    assign pred_phase = phase_reg[nslot_reg];
    assign mark_phase = phase_reg[idx_reg];
    assign slot_owner = ram_rdata[RAM_W-1:TIME_W];
    assign slot_due   = ram_rdata[TIME_W-1:0];
    assign grid_sum   = {1'b0, disp_reg} + {1'b0, period_reg};
    assign neg_diff   = '0 - diff_reg;

    // required phase and next phase for each mark action
    always_comb
    begin
        phase_ok    = 1'b0;
        phase_after = mark_phase;
        unique case (act_reg)
            ACT_WAIT:
            begin
                phase_ok    = (mark_phase == PH_PRED);
                phase_after = PH_WAITED;
            end
            ACT_BEGIN:
            begin
                phase_ok    = (mark_phase == PH_WAITED);
                phase_after = PH_BEGUN;
            end
            ACT_DISCARD:
            begin
                phase_ok    = (mark_phase == PH_WAITED) || (mark_phase == PH_BEGUN);
                phase_after = PH_READY;
            end
            ACT_DELIVER:
            begin
                phase_ok    = (mark_phase == PH_BEGUN);
                phase_after = PH_READY;
            end
            default:
            begin
                phase_ok    = 1'b0;
                phase_after = mark_phase;
            end
        endcase
    end

    // divider operands: grid offset over period
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = floor_reg - last_disp_reg;
        div_divisor  = period_reg;
        if (state_reg == S_PRED && period_reg != '0 && !(last_disp_reg > floor_reg))
        begin
            div_start = 1'b1;
        end
    end

    assign ram_we    = (state_reg == S_FIN2);
    assign ram_wdata = {nid, due_reg - HALF_MS_NS};

    assign in_ready = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_RESP) && (!out_valid_reg || out_ready);
    assign pred_ok  = (act_reg == ACT_PREDICT) && (st_reg == ST_OK);
    assign dlv_ok   = (act_reg == ACT_DELIVER) && (st_reg == ST_OK);

    fpst_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    fpst_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (nslot_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            act_reg       <= ACT_SAMPLE;
            id_cnt_reg    <= '0;
            nslot_reg     <= SLOT_W'(1);
            last_ret_reg  <= '0;
            last_disp_reg <= '0;
            period_reg    <= '0;
            extra_reg     <= '0;
            st_reg        <= ST_OK;
            for (int i = 0; i < SLOTS; i++)
            begin
                phase_reg[i] <= PH_READY;
            end
        end
        else
        begin
            // raise the result on load, drop it once taken
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg   <= action;
                        st_reg    <= ST_OK;
                        state_reg <= S_DISP;
                        if (action == ACT_SAMPLE)
                        begin
                            last_disp_reg <= sample_display_ns;
                            period_reg    <= sample_period_ns;
                            extra_reg     <= sample_extra_ns;
                        end
                    end
                end
                S_DISP:
                begin
                    if (act_reg == ACT_PREDICT)
                    begin
                        if (pred_phase != PH_READY)
                        begin
                            st_reg    <= ST_BUSY;
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_PRED;
                        end
                    end
                    else if (act_reg == ACT_SAMPLE || act_reg > ACT_DELIVER)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_PRED:
                begin
                    if (div_start)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_FIN1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    state_reg <= S_FIN1;
                end
                S_FIN1:
                begin
                    state_reg <= S_FIN2;
                end
                S_FIN2:
                begin
                    // book the slot and advance the id
                    phase_reg[nslot_reg] <= PH_PRED;
                    id_cnt_reg           <= nid;
                    last_ret_reg         <= disp_reg;
                    if (nid == '1 || nslot_reg == SLOT_W'(SLOTS - 1))
                    begin
                        nslot_reg <= '0;
                    end
                    else
                    begin
                        nslot_reg <= nslot_reg + 1'b1;
                    end
                    state_reg <= S_RESP;
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (mark_phase == PH_READY || slot_owner != fid_reg)
                    begin
                        st_reg    <= ST_MISMATCH;
                        state_reg <= S_RESP;
                    end
                    else if (!phase_ok)
                    begin
                        st_reg    <= ST_WRONG;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        phase_reg[idx_reg] <= phase_after;
                        state_reg <= (act_reg == ACT_DELIVER) ? S_DLV : S_RESP;
                    end
                end
                S_DLV:
                begin
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            now_reg <= now_ns;
            fid_reg <= mark_id;
            idx_reg <= mark_id[SLOT_W-1:0];
        end

        // later of now and the last returned time
        if (state_reg == S_DISP)
        begin
            floor_reg <= (now_reg < last_ret_reg) ? last_ret_reg : now_reg;
        end

        // display time without a grid search
        if (state_reg == S_PRED)
        begin
            if (period_reg == '0)
            begin
                disp_reg <= floor_reg;
            end
            else if (last_disp_reg > floor_reg)
            begin
                disp_reg <= last_disp_reg;
            end
        end

        // grid point at or below the floor, then step one period
        if (state_reg == S_DIV && div_done)
        begin
            disp_reg <= floor_reg - div_rem;
        end
        if (state_reg == S_ADD)
        begin
            disp_reg <= grid_sum[TIME_W] ? '1 : grid_sum[TIME_W-1:0];
        end

        if (state_reg == S_FIN1)
        begin
            wake_reg <= disp_reg - period_reg;
            due_reg  <= disp_reg - extra_reg;
        end

        if (state_reg == S_CHK)
        begin
            diff_reg <= slot_due - now_reg;
        end

        // magnitude of the early or late difference
        if (state_reg == S_DLV)
        begin
            late_reg <= diff_reg[TIME_W-1];
            if (diff_reg[TIME_W-1])
            begin
                off_reg <= neg_diff[TIME_W-1] ? '1 : neg_diff[OFF_W-1:0];
            end
            else
            begin
                off_reg <= diff_reg[OFF_W-1:0];
            end
        end

        // result register
        if (load_out)
        begin
            status       <= st_reg;
            new_frame_id <= pred_ok ? id_cnt_reg : '0;
            display_ns   <= pred_ok ? disp_reg : '0;
            wake_ns      <= pred_ok ? wake_reg : '0;
            period_ns    <= pred_ok ? period_reg : '0;
            late         <= dlv_ok ? late_reg : 1'b0;
            offset_ns    <= dlv_ok ? off_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire
